### rtl/core/ksc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the keyword substitution cipher core.
// No dependencies; used by every module in rtl/core.
package ksc_pkg;

   localparam int NUM_LETTERS = 26;
   localparam int LETTER_W    = 5;

   localparam logic [LETTER_W-1:0] LAST_IDX  = LETTER_W'(NUM_LETTERS - 1);
   localparam logic [LETTER_W-1:0] FILL_FULL = LETTER_W'(NUM_LETTERS);

   localparam logic [7:0] ASCII_UPPER_A = 8'h41;
   localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
   localparam logic [7:0] ASCII_LOWER_A = 8'h61;
   localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;

   typedef enum logic [1:0] {
      OP_KEY     = 2'd0,
      OP_FINISH  = 2'd1,
      OP_ENCRYPT = 2'd2,
      OP_DECRYPT = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      BK_RUN,
      BK_FILL,
      BK_EMIT
   } back_state_type;

   typedef logic [NUM_LETTERS-1:0][LETTER_W-1:0] table_type;

   // One classified request as it sits in the queue.
   typedef struct packed {
      op_type              op;
      logic [7:0]          in_byte;
      logic                is_letter;
      logic [LETTER_W-1:0] letter;
   } item_type;

   // Head of the queue as the back end sees it.
   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

endpackage

### rtl/core/keyword_substitution_cipher_core.sv
`timescale 1ns / 1ps
// Top level of the keyword substitution cipher core.
// Depends on ksc_pkg, ksc_front, ksc_queue and ksc_back.

// A request beat is taken when start is high and busy is low. Keyword, encrypt and
// decrypt beats are handled in the back end's run state and stream at one per cycle
// while no finish walk runs; with the queue empty and the back end idle, an encrypt or
// decrypt result passes the queue entry and the result register before rsp_strobe.
// A finish beat is taken from the queue; then a 26-step walk appends the unused
// letters, and a second 26-step walk builds the inverse table and sends the 26
// alphabet letters, one per cycle, the last with rsp_last.
// Requests queue in a QUEUE_DEPTH-entry queue meanwhile, and busy is high while
// that queue is full. Results are presented for exactly one cycle with
// rsp_strobe and cannot be held off, so the receiver must take every beat.
module keyword_substitution_cipher_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_op,
   input  logic [7:0] req_in_byte,
   output logic       rsp_strobe,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last,
   output logic       rsp_err
);

   logic              queue_full;
   logic              push;
   logic              pop;
   ksc_pkg::item_type push_item;
   ksc_pkg::head_type head;

   ksc_front u_front (
      .start       (start),
      .req_op      (req_op),
      .req_in_byte (req_in_byte),
      .queue_full  (queue_full),
      .busy        (busy),
      .push        (push),
      .push_item   (push_item)
   );

   ksc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (queue_full),
      .head      (head)
   );

   ksc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .pop          (pop),
      .rsp_strobe   (rsp_strobe),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .rsp_err      (rsp_err)
   );

endmodule

### rtl/core/ksc_front.sv
`timescale 1ns / 1ps
// Front end: takes request beats and classifies the byte into a letter index.
// Depends on ksc_pkg.
module ksc_front (
   input  logic              start,
   input  logic [1:0]        req_op,
   input  logic [7:0]        req_in_byte,
   input  logic              queue_full,
   output logic              busy,
   output logic              push,
   output ksc_pkg::item_type push_item
);

   logic is_upper;
   logic is_lower;
   logic [7:0] offset;

   assign is_upper = (req_in_byte >= ksc_pkg::ASCII_UPPER_A)
                     && (req_in_byte <= ksc_pkg::ASCII_UPPER_Z);
   assign is_lower = (req_in_byte >= ksc_pkg::ASCII_LOWER_A)
                     && (req_in_byte <= ksc_pkg::ASCII_LOWER_Z);

   always_comb begin
      if (is_lower) begin
         offset = req_in_byte - ksc_pkg::ASCII_LOWER_A;
      end else begin
         offset = req_in_byte - ksc_pkg::ASCII_UPPER_A;
      end
   end

   assign busy = queue_full;
   assign push = start && !queue_full;

   always_comb begin
      push_item.op        = ksc_pkg::op_type'(req_op);
      push_item.in_byte   = req_in_byte;
      push_item.is_letter = is_upper || is_lower;
      push_item.letter    = offset[ksc_pkg::LETTER_W-1:0];
   end

endmodule

### rtl/core/ksc_queue.sv
`timescale 1ns / 1ps
// Short queue of classified items between the front and back ends.
// Depends on ksc_pkg.
module ksc_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ksc_pkg::item_type push_item,
   input  logic              pop,
   output logic              full,
   output ksc_pkg::head_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   ksc_pkg::item_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign full       = (count_ff == CNT_FULL);
   assign head.valid = (count_ff != '0);
   assign head.item  = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count exceeds depth");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (rd_ptr_ff == wr_ptr_ff))
      else $error("empty queue with pointers apart");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("push without pop did not grow the queue");

endmodule

### rtl/core/ksc_back.sv
`timescale 1ns / 1ps
// Back end: keyword tables, finish walks and the registered result beat.
// Depends on ksc_pkg.
module ksc_back (
   input  logic              clock,
   input  logic              reset,
   input  ksc_pkg::head_type head,
   output logic              pop,
   output logic              rsp_strobe,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_last,
   output logic              rsp_err
);

   ksc_pkg::back_state_type state_ff, state_in;

   logic [ksc_pkg::LETTER_W-1:0]    idx_ff, idx_in;
   logic [ksc_pkg::NUM_LETTERS-1:0] seen_ff, seen_in;
   logic [ksc_pkg::LETTER_W-1:0]    fill_ff, fill_in;
   logic                            keying_ff, keying_in;
   ksc_pkg::table_type              fwd_ff, fwd_in;
   ksc_pkg::table_type              inv_ff, inv_in;

   logic       rsp_strobe_ff, rsp_strobe_in;
   logic [7:0] rsp_out_byte_ff, rsp_out_byte_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       rsp_err_ff, rsp_err_in;

   logic                         at_last;
   logic [ksc_pkg::LETTER_W-1:0] lookup;

   assign at_last = (idx_ff == ksc_pkg::LAST_IDX);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ksc_pkg::BK_RUN: begin
            if (head.valid && head.item.op == ksc_pkg::OP_FINISH) begin
               state_in = ksc_pkg::BK_FILL;
            end
         end
         ksc_pkg::BK_FILL: begin
            if (at_last) begin
               state_in = ksc_pkg::BK_EMIT;
            end
         end
         ksc_pkg::BK_EMIT: begin
            if (at_last) begin
               state_in = ksc_pkg::BK_RUN;
            end
         end
         default: state_in = ksc_pkg::BK_RUN;
      endcase
   end

   // Outputs of the sequencer: pop, walk index and the result beat
   always_comb begin
      pop             = 1'b0;
      idx_in          = '0;
      rsp_strobe_in   = 1'b0;
      rsp_out_byte_in = head.item.in_byte;
      rsp_last_in     = 1'b0;
      rsp_err_in      = 1'b0;
      lookup          = (head.item.op == ksc_pkg::OP_ENCRYPT)
                        ? fwd_ff[head.item.letter] : inv_ff[head.item.letter];
      unique case (state_ff)
         ksc_pkg::BK_RUN: begin
            pop = head.valid;
            if (head.valid && (head.item.op == ksc_pkg::OP_ENCRYPT
                               || head.item.op == ksc_pkg::OP_DECRYPT)) begin
               rsp_strobe_in = 1'b1;
               rsp_last_in   = 1'b1;
               if (keying_ff) begin
                  rsp_err_in = 1'b1;
               end else if (head.item.is_letter) begin
                  rsp_out_byte_in = ksc_pkg::ASCII_UPPER_A + {3'b000, lookup};
               end
            end
         end
         ksc_pkg::BK_FILL: begin
            idx_in = at_last ? '0 : idx_ff + 1'b1;
         end
         ksc_pkg::BK_EMIT: begin
            idx_in          = at_last ? '0 : idx_ff + 1'b1;
            rsp_strobe_in   = 1'b1;
            rsp_out_byte_in = ksc_pkg::ASCII_UPPER_A + {3'b000, fwd_ff[idx_ff]};
            rsp_last_in     = at_last;
         end
         default: begin
         end
      endcase
   end

   // Table and keyword bookkeeping
   always_comb begin
      seen_in   = seen_ff;
      fill_in   = fill_ff;
      keying_in = keying_ff;
      fwd_in    = fwd_ff;
      inv_in    = inv_ff;
      unique case (state_ff)
         ksc_pkg::BK_RUN: begin
            if (head.valid && head.item.op == ksc_pkg::OP_KEY) begin
               // The first keyword beat after reset or a finish starts a fresh alphabet.
               if (!keying_ff) begin
                  seen_in   = '0;
                  fill_in   = '0;
                  keying_in = 1'b1;
               end
               if (head.item.is_letter && !seen_in[head.item.letter]
                   && fill_in < ksc_pkg::FILL_FULL) begin
                  fwd_in[fill_in]           = head.item.letter;
                  fill_in                   = fill_in + 1'b1;
                  seen_in[head.item.letter] = 1'b1;
               end
            end
         end
         ksc_pkg::BK_FILL: begin
            if (!seen_ff[idx_ff] && fill_ff < ksc_pkg::FILL_FULL) begin
               fwd_in[fill_ff] = idx_ff;
               fill_in         = fill_ff + 1'b1;
               seen_in[idx_ff] = 1'b1;
            end
         end
         ksc_pkg::BK_EMIT: begin
            inv_in[fwd_ff[idx_ff]] = idx_ff;
            if (at_last) begin
               keying_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ksc_pkg::BK_RUN;
         idx_ff        <= '0;
         seen_ff       <= '0;
         fill_ff       <= '0;
         keying_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < ksc_pkg::NUM_LETTERS; i++) begin
            fwd_ff[i] <= ksc_pkg::LETTER_W'(i);
            inv_ff[i] <= ksc_pkg::LETTER_W'(i);
         end
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         seen_ff       <= seen_in;
         fill_ff       <= fill_in;
         keying_ff     <= keying_in;
         rsp_strobe_ff <= rsp_strobe_in;
         fwd_ff        <= fwd_in;
         inv_ff        <= inv_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_out_byte_ff <= rsp_out_byte_in;
      rsp_last_ff     <= rsp_last_in;
      rsp_err_ff      <= rsp_err_in;
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_out_byte = rsp_out_byte_ff;
   assign rsp_last     = rsp_last_ff;
   assign rsp_err      = rsp_err_ff;

   a_fill_matches_seen: assert property (@(posedge clock) disable iff (reset)
      fill_ff == ksc_pkg::LETTER_W'($countones(seen_ff)))
      else $error("fill count disagrees with seen letters");

   a_emit_complete: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ksc_pkg::BK_EMIT) |-> (fill_ff == ksc_pkg::FILL_FULL))
      else $error("alphabet emitted before it was complete");

   a_no_pop_in_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ksc_pkg::BK_RUN) |-> !pop)
      else $error("queue popped during a finish walk");

   a_flags_need_strobe: assert property (@(posedge clock) disable iff (reset)
      (rsp_last_ff || rsp_err_ff) |-> rsp_strobe_ff)
      else $error("result flags raised without a strobe");

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for keyword_substitution_cipher_core: directed keyword and cipher
// beats, then random keyword sessions, all checked against a cycle-free alphabet predictor.
// Depends on ksc_pkg and the core RTL only.
module tb;

   typedef struct {
      logic [7:0] out_byte;
      logic       last;
      logic       err;
   } cipher_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic [1:0] req_op = ksc_pkg::OP_KEY;
   logic [7:0] req_in_byte = 8'h00;
   logic       busy;
   logic       rsp_strobe;
   logic [7:0] rsp_out_byte;
   logic       rsp_last;
   logic       rsp_err;

   // Predictor state: the keyword alphabet as the block should hold it.
   logic [ksc_pkg::NUM_LETTERS-1:0] letters_used;
   logic [ksc_pkg::LETTER_W-1:0]    alpha_fwd [ksc_pkg::NUM_LETTERS];
   logic [ksc_pkg::LETTER_W-1:0]    alpha_inv [ksc_pkg::NUM_LETTERS];
   int                              letters_placed;
   bit                              keyword_open;

   cipher_beat_type expected_beats [$];
   int              mismatches = 0;
   int              beats_sent = 0;
   bit              gaps_on = 1'b1;

   keyword_substitution_cipher_core dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_op      (req_op),
      .req_in_byte (req_in_byte),
      .rsp_strobe  (rsp_strobe),
      .rsp_out_byte(rsp_out_byte),
      .rsp_last    (rsp_last),
      .rsp_err     (rsp_err)
   );

   always #5 clock = ~clock;

   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

   function automatic int letter_of(logic [7:0] b);
      if (b >= ksc_pkg::ASCII_UPPER_A && b <= ksc_pkg::ASCII_UPPER_Z)
         return int'(b - ksc_pkg::ASCII_UPPER_A);
      if (b >= ksc_pkg::ASCII_LOWER_A && b <= ksc_pkg::ASCII_LOWER_Z)
         return int'(b - ksc_pkg::ASCII_LOWER_A);
      return -1;
   endfunction

   function automatic logic [7:0] rand_letter();
      logic [7:0] base;
      base = $urandom_range(0, 1) ? ksc_pkg::ASCII_UPPER_A : ksc_pkg::ASCII_LOWER_A;
      return base + 8'($urandom_range(0, ksc_pkg::NUM_LETTERS - 1));
   endfunction

   task automatic predict_alphabet(input ksc_pkg::op_type op, input logic [7:0] b);
      int              idx;
      cipher_beat_type beat;
      idx = letter_of(b);
      case (op)
         ksc_pkg::OP_KEY: begin
            if (!keyword_open) begin
               letters_used   = '0;
               letters_placed = 0;
               keyword_open   = 1'b1;
            end
            if (idx >= 0 && !letters_used[idx] && letters_placed < ksc_pkg::NUM_LETTERS) begin
               alpha_fwd[letters_placed] = ksc_pkg::LETTER_W'(idx);
               letters_placed++;
               letters_used[idx] = 1'b1;
            end
         end
         ksc_pkg::OP_FINISH: begin
            for (int i = 0; i < ksc_pkg::NUM_LETTERS; i++) begin
               if (!letters_used[i] && letters_placed < ksc_pkg::NUM_LETTERS) begin
                  alpha_fwd[letters_placed] = ksc_pkg::LETTER_W'(i);
                  letters_placed++;
                  letters_used[i] = 1'b1;
               end
            end
            for (int i = 0; i < ksc_pkg::NUM_LETTERS; i++)
               alpha_inv[alpha_fwd[i]] = ksc_pkg::LETTER_W'(i);
            keyword_open = 1'b0;
            for (int i = 0; i < ksc_pkg::NUM_LETTERS; i++) begin
               beat.out_byte = ksc_pkg::ASCII_UPPER_A + 8'(alpha_fwd[i]);
               beat.last     = (i == ksc_pkg::NUM_LETTERS - 1);
               beat.err      = 1'b0;
               expected_beats.push_back(beat);
            end
         end
         default: begin
            beat.last = 1'b1;
            beat.err  = 1'b0;
            if (keyword_open) begin
               // Cipher beats are refused while a keyword is still open.
               beat.out_byte = b;
               beat.err      = 1'b1;
            end else if (idx < 0) begin
               beat.out_byte = b;
            end else if (op == ksc_pkg::OP_ENCRYPT) begin
               beat.out_byte = ksc_pkg::ASCII_UPPER_A + 8'(alpha_fwd[idx]);
            end else begin
               beat.out_byte = ksc_pkg::ASCII_UPPER_A + 8'(alpha_inv[idx]);
            end
            expected_beats.push_back(beat);
         end
      endcase
   endtask

   // Called just after a rising edge; returns just after the edge that took the beat,
   // leaving start high so that a following beat can go out without a gap.
   task automatic send_beat(input ksc_pkg::op_type op, input logic [7:0] b);
      bit taken;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start       <= 1'b1;
      req_op      <= op;
      req_in_byte <= b;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
      predict_alphabet(op, b);
      beats_sent++;
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (expected_beats.size() != 0) @(posedge clock);
   endtask

   // Results are sampled mid-cycle, well away from the edge that takes them.
   always @(negedge clock) begin
      cipher_beat_type want;
      if (!reset && rsp_strobe) begin
         if (expected_beats.size() == 0) begin
            $display("%0t: unexpected result beat out_byte=%02h last=%0b err=%0b",
                     $time, rsp_out_byte, rsp_last, rsp_err);
            mismatches++;
         end else begin
            want = expected_beats.pop_front();
            if (rsp_out_byte !== want.out_byte) begin
               $display("%0t: out_byte expected %02h actual %02h",
                        $time, want.out_byte, rsp_out_byte);
               mismatches++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last expected %0b actual %0b", $time, want.last, rsp_last);
               mismatches++;
            end
            if (rsp_err !== want.err) begin
               $display("%0t: err expected %0b actual %0b", $time, want.err, rsp_err);
               mismatches++;
            end
         end
      end
   end

   // Finish with no keyword since reset gives the plain alphabet, and a second finish
   // after two cipher beats must repeat it unchanged.
   task automatic test_default_alphabet();
      send_beat(ksc_pkg::OP_FINISH, 8'h00);
      send_beat(ksc_pkg::OP_ENCRYPT, "m");
      send_beat(ksc_pkg::OP_DECRYPT, 8'h5A);
      send_beat(ksc_pkg::OP_FINISH, 8'hFF);
   endtask

   task automatic test_keyword_edges();
      logic [7:0] kw [8] = '{"z", "E", "b", "b", "!", 8'h00, 8'hFF, "a"};
      logic [7:0] probe [4] = '{"A", "z", 8'h7B, 8'h40};
      logic [7:0] back [4] = '{"Z", "a", 8'h60, 8'h5B};
      foreach (kw[i]) send_beat(ksc_pkg::OP_KEY, kw[i]);
      send_beat(ksc_pkg::OP_ENCRYPT, "Q");
      send_beat(ksc_pkg::OP_DECRYPT, 8'h80);
      send_beat(ksc_pkg::OP_FINISH, 8'h55);
      foreach (probe[i]) send_beat(ksc_pkg::OP_ENCRYPT, probe[i]);
      foreach (back[i]) send_beat(ksc_pkg::OP_DECRYPT, back[i]);
   endtask

   // A keyword that holds every letter fills the alphabet; the extra letter must be dropped.
   task automatic test_full_alphabet();
      int order [ksc_pkg::NUM_LETTERS];
      int j;
      int t;
      foreach (order[i]) order[i] = i;
      for (int i = ksc_pkg::NUM_LETTERS - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      foreach (order[i])
         send_beat(ksc_pkg::OP_KEY, ($urandom_range(0, 1) ? ksc_pkg::ASCII_LOWER_A
                                                           : ksc_pkg::ASCII_UPPER_A)
                                    + 8'(order[i]));
      send_beat(ksc_pkg::OP_KEY, "q");
      send_beat(ksc_pkg::OP_FINISH, 8'($urandom_range(0, 255)));
      repeat (6) send_beat(ksc_pkg::op_type'($urandom_range(2, 3)), rand_letter());
   endtask

   // Mostly well-formed sessions (keyword, finish, cipher beats) with a little noise.
   task automatic test_random_sessions(input int target);
      int limit;
      int kw_len;
      limit = beats_sent + target;
      while (beats_sent < limit) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4))
               send_beat(ksc_pkg::op_type'($urandom_range(0, 3)),
                         8'($urandom_range(0, 255)));
         end else begin
            kw_len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
            repeat (kw_len) begin
               send_beat(ksc_pkg::OP_KEY, ($urandom_range(0, 4) != 0)
                                          ? rand_letter() : 8'($urandom_range(0, 255)));
               if ($urandom_range(0, 9) == 0)
                  send_beat(ksc_pkg::op_type'($urandom_range(2, 3)),
                            8'($urandom_range(0, 255)));
            end
            send_beat(ksc_pkg::OP_FINISH, 8'($urandom_range(0, 255)));
            repeat ($urandom_range(3, 15))
               send_beat(ksc_pkg::op_type'($urandom_range(2, 3)),
                         ($urandom_range(0, 3) != 0) ? rand_letter()
                                                     : 8'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      letters_used   = '0;
      letters_placed = 0;
      keyword_open   = 1'b0;
      foreach (alpha_fwd[i]) begin
         alpha_fwd[i] = ksc_pkg::LETTER_W'(i);
         alpha_inv[i] = ksc_pkg::LETTER_W'(i);
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_alphabet();
      test_keyword_edges();
      test_random_sessions(100);
      wait_drained();
      test_full_alphabet();
      test_random_sessions(90);
      gaps_on = 1'b0;
      test_random_sessions(80);

      start <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (mismatches == 0 && expected_beats.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule

### filelist.f
rtl/core/ksc_pkg.sv
rtl/core/ksc_front.sv
rtl/core/ksc_queue.sv
rtl/core/ksc_back.sv
rtl/core/keyword_substitution_cipher_core.sv
test/tb.sv
